// ===== rtl/core/bns_pkg.sv =====
`default_nettype none

package bns_pkg;

    localparam int STORE_BYTES     = 65536;
    localparam int PALETTE_ENTRIES = 256;
    localparam int STORE_AW        = $clog2(STORE_BYTES);
    localparam int PAL_AW          = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;

    localparam int SRC_W      = 14;
    localparam int SCR_W      = 13;
    localparam int COORD_W    = 12;
    localparam int INDEX_W    = 16;
    localparam int DATA_W     = 24;
    localparam int COLOUR_W   = 24;
    localparam int BYTE_W     = 8;
    localparam int BPP_W      = 3;

    localparam int QUOT_W     = SRC_W;
    localparam int DIVIDEND_W = COORD_W + SRC_W;
    localparam int DIVISOR_W  = SCR_W;
    localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);

    localparam int STRIDE_W   = SRC_W + BPP_W;
    localparam int SXB_W      = QUOT_W + BPP_W;
    localparam int ADDR_W     = SRC_W + STRIDE_W + 1;

    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [1:0] CMD_PAL_WR = 2'd0;
    localparam logic [1:0] CMD_PIX_WR = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] FMT_PAL8  = 2'd0;
    localparam logic [1:0] FMT_RGB24 = 2'd1;

    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PIX_FMT    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOTTOM_UP  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCR_WIDTH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SCR_HEIGHT = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_DIV,
        ST_ROW,
        ST_MUL,
        ST_ADDR,
        ST_B0,
        ST_B1,
        ST_B2,
        ST_B3,
        ST_PAL,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/bns_div.sv =====
`default_nettype none

module bns_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [bns_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [bns_pkg::DIVISOR_W-1:0]     divisor,
    output logic [bns_pkg::QUOT_W-1:0]        quotient,
    output logic                              done
);

    logic [bns_pkg::DIVISOR_W-1:0] rem_reg;
    logic [bns_pkg::DIVISOR_W-1:0] dvs_reg;
    logic [bns_pkg::QUOT_W-1:0]    quo_reg;
    logic [bns_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          done_reg;
    logic [bns_pkg::DIVISOR_W:0]   trial;
    logic [bns_pkg::DIVISOR_W:0]   diff;
    logic                          fits;

    // quotient is known to fit, so the upper dividend bits start as remainder
    assign trial = {rem_reg, quo_reg[bns_pkg::QUOT_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= bns_pkg::DIV_CNT_W'(bns_pkg::QUOT_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == bns_pkg::DIV_CNT_W'(1)) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= bns_pkg::DIVISOR_W'(dividend >> bns_pkg::QUOT_W);
            quo_reg <= dividend[bns_pkg::QUOT_W-1:0];
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? diff[bns_pkg::DIVISOR_W-1:0] : trial[bns_pkg::DIVISOR_W-1:0];
            quo_reg <= {quo_reg[bns_pkg::QUOT_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_nearest_scaler.sv =====
// Nearest-neighbour bitmap scaler with palette and pixel byte stores.
// Requests arrive on the s_ stream: tuser carries the command, tdata the
// byte index, data word and screen coordinate. A palette or pixel byte write
// gives no result. A read maps the screen coordinate to a source pixel,
// fetches it and returns one result on the m_ stream: tdata is the colour
// 0xRRGGBB, tuser is the out_of_range flag.
// A read runs through the two 14-step shift-subtract dividers (one per axis,
// run side by side) and then the one-byte-per-cycle read port of the pixel
// store; an off-screen read skips both. One read is in flight at a time;
// s_tready is low while it is in work. A finished result sits in the output
// register, and the next request is taken while it waits; a further read
// holds its result until m_tready. Geometry and format registers sit on the
// APB port, and the user must write them only while the block is idle; the
// block itself does not enforce this. Reset (aresetn low, synchronous)
// restores the register defaults and empties the output; store contents are
// undefined until written.
`default_nettype none

module bitmap_nearest_scaler (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,  // index, data, out_x, out_y
    input  logic [1:0]                  s_tuser,  // command
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,  // colour
    output logic                        m_tuser,  // out_of_range
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bns_pkg::APB_AW-1:0]  paddr,
    input  logic [bns_pkg::APB_DW-1:0]  pwdata,
    output logic [bns_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    logic [bns_pkg::SRC_W-1:0] src_width_reg;
    logic [bns_pkg::SRC_W-1:0] src_height_reg;
    logic [1:0]                pix_fmt_reg;
    logic                      bottom_up_reg;
    logic [bns_pkg::SCR_W-1:0] scr_width_reg;
    logic [bns_pkg::SCR_W-1:0] scr_height_reg;

    logic                           cfg_wr;
    logic [bns_pkg::REG_IDX_W-1:0]  cfg_idx;

    bns_pkg::state_t state_reg;
    bns_pkg::state_t state_next;

    logic                          accept;
    logic [1:0]                    in_cmd;
    logic [bns_pkg::INDEX_W-1:0]   in_index;
    logic [bns_pkg::DATA_W-1:0]    in_data;
    logic [bns_pkg::COORD_W-1:0]   in_x;
    logic [bns_pkg::COORD_W-1:0]   in_y;

    logic [bns_pkg::COLOUR_W-1:0]  pal_mem [bns_pkg::PALETTE_ENTRIES];
    logic [bns_pkg::BYTE_W-1:0]    pix_mem [bns_pkg::STORE_BYTES];
    logic [bns_pkg::COLOUR_W-1:0]  pal_rd_reg;
    logic [bns_pkg::BYTE_W-1:0]    pix_rd_reg;
    logic                          pal_we;
    logic                          pix_we;

    logic [bns_pkg::SRC_W-1:0]     sw_eff;
    logic [bns_pkg::SRC_W-1:0]     sh_eff;
    logic [bns_pkg::SCR_W-1:0]     dw_eff;
    logic [bns_pkg::SCR_W-1:0]     dh_eff;
    logic                          fmt_pal;
    logic [bns_pkg::BPP_W-1:0]     bpp;

    logic [bns_pkg::COORD_W-1:0]   x_reg;
    logic [bns_pkg::COORD_W-1:0]   y_reg;
    logic                          off_screen;
    logic                          div_start;
    logic [bns_pkg::QUOT_W-1:0]    sx_q;
    logic [bns_pkg::QUOT_W-1:0]    sy_q;
    logic                          div_x_done;
    logic                          div_y_done;

    logic [bns_pkg::SRC_W-1:0]     row_reg;
    logic [bns_pkg::STRIDE_W-1:0]  stride_reg;
    logic [bns_pkg::SXB_W-1:0]     sxb_reg;
    logic [bns_pkg::SXB_W-1:0]     sxl_reg;
    logic [bns_pkg::ADDR_W-1:0]    prod_reg;
    logic [bns_pkg::ADDR_W-1:0]    addr_sum;
    logic [bns_pkg::ADDR_W-1:0]    last_sum;
    logic                          addr_oor;
    logic [bns_pkg::STORE_AW-1:0]  addr_reg;
    logic [bns_pkg::SXB_W-1:0]     sxb_calc;
    logic [bns_pkg::STRIDE_W-1:0]  stride_calc;
    logic                          pal_ok_reg;

    logic [bns_pkg::COLOUR_W-1:0]  res_colour_reg;
    logic                          res_oor_reg;

    logic                          out_free;
    logic                          out_load;
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [bns_pkg::COLOUR_W-1:0]  m_tdata_reg;
    logic                          m_tuser_reg;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[bns_pkg::APB_AW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= bns_pkg::SRC_W'(1);
            src_height_reg <= bns_pkg::SRC_W'(1);
            pix_fmt_reg    <= bns_pkg::FMT_RGB24;
            bottom_up_reg  <= 1'b1;
            scr_width_reg  <= bns_pkg::SCR_W'(640);
            scr_height_reg <= bns_pkg::SCR_W'(480);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                bns_pkg::REG_SRC_WIDTH:  src_width_reg  <= pwdata[bns_pkg::SRC_W-1:0];
                bns_pkg::REG_SRC_HEIGHT: src_height_reg <= pwdata[bns_pkg::SRC_W-1:0];
                bns_pkg::REG_PIX_FMT:    pix_fmt_reg    <= pwdata[1:0];
                bns_pkg::REG_BOTTOM_UP:  bottom_up_reg  <= pwdata[0];
                bns_pkg::REG_SCR_WIDTH:  scr_width_reg  <= pwdata[bns_pkg::SCR_W-1:0];
                bns_pkg::REG_SCR_HEIGHT: scr_height_reg <= pwdata[bns_pkg::SCR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            bns_pkg::REG_SRC_WIDTH:  prdata = bns_pkg::APB_DW'(src_width_reg);
            bns_pkg::REG_SRC_HEIGHT: prdata = bns_pkg::APB_DW'(src_height_reg);
            bns_pkg::REG_PIX_FMT:    prdata = bns_pkg::APB_DW'(pix_fmt_reg);
            bns_pkg::REG_BOTTOM_UP:  prdata = bns_pkg::APB_DW'(bottom_up_reg);
            bns_pkg::REG_SCR_WIDTH:  prdata = bns_pkg::APB_DW'(scr_width_reg);
            bns_pkg::REG_SCR_HEIGHT: prdata = bns_pkg::APB_DW'(scr_height_reg);
            default:                 prdata = '0;
        endcase
    end

    // request fields
    assign accept   = s_tvalid & s_tready;
    assign in_cmd   = s_tuser;
    assign in_index = s_tdata[15:0];
    assign in_data  = s_tdata[39:16];
    assign in_x     = s_tdata[51:40];
    assign in_y     = s_tdata[63:52];

    assign pal_we = accept && (in_cmd == bns_pkg::CMD_PAL_WR)
                    && ((bns_pkg::ADDR_W'(in_index)) < bns_pkg::ADDR_W'(bns_pkg::PALETTE_ENTRIES));
    assign pix_we = accept && (in_cmd == bns_pkg::CMD_PIX_WR)
                    && ((bns_pkg::ADDR_W'(in_index)) < bns_pkg::ADDR_W'(bns_pkg::STORE_BYTES));

    // stores
    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[bns_pkg::PAL_AW'(in_index)] <= in_data;
        end
        pal_rd_reg <= pal_mem[bns_pkg::PAL_AW'(pix_rd_reg)];
    end

    always_ff @(posedge aclk) begin
        if (pix_we) begin
            pix_mem[bns_pkg::STORE_AW'(in_index)] <= in_data[bns_pkg::BYTE_W-1:0];
        end
        pix_rd_reg <= pix_mem[addr_reg];
    end

    // geometry
    assign sw_eff  = (src_width_reg  == '0) ? bns_pkg::SRC_W'(1) : src_width_reg;
    assign sh_eff  = (src_height_reg == '0) ? bns_pkg::SRC_W'(1) : src_height_reg;
    assign dw_eff  = (scr_width_reg  == '0) ? bns_pkg::SCR_W'(1) : scr_width_reg;
    assign dh_eff  = (scr_height_reg == '0) ? bns_pkg::SCR_W'(1) : scr_height_reg;
    assign fmt_pal = (pix_fmt_reg == bns_pkg::FMT_PAL8);
    assign bpp     = fmt_pal ? 3'd1 : ((pix_fmt_reg == bns_pkg::FMT_RGB24) ? 3'd3 : 3'd4);

    assign off_screen = ({1'b0, x_reg} >= dw_eff) || ({1'b0, y_reg} >= dh_eff);

    bns_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (bns_pkg::DIVIDEND_W'(x_reg) * bns_pkg::DIVIDEND_W'(sw_eff)),
        .divisor  (dw_eff),
        .quotient (sx_q),
        .done     (div_x_done)
    );

    bns_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (bns_pkg::DIVIDEND_W'(y_reg) * bns_pkg::DIVIDEND_W'(sh_eff)),
        .divisor  (dh_eff),
        .quotient (sy_q),
        .done     (div_y_done)
    );

    assign sxb_calc    = bns_pkg::SXB_W'(sx_q) * bns_pkg::SXB_W'(bpp);
    assign stride_calc = (bns_pkg::STRIDE_W'(sw_eff) * bns_pkg::STRIDE_W'(bpp)
                          + bns_pkg::STRIDE_W'(3)) & ~bns_pkg::STRIDE_W'(3);
    assign addr_sum    = prod_reg + bns_pkg::ADDR_W'(sxb_reg);
    assign last_sum    = prod_reg + bns_pkg::ADDR_W'(sxl_reg);
    assign addr_oor    = last_sum >= bns_pkg::ADDR_W'(bns_pkg::STORE_BYTES);
    assign out_free    = !m_tvalid_reg || m_tready;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bns_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bns_pkg::ST_IDLE: begin
                if (accept && (in_cmd == bns_pkg::CMD_READ)) begin
                    state_next = bns_pkg::ST_CHK;
                end
            end
            bns_pkg::ST_CHK:  state_next = off_screen ? bns_pkg::ST_DONE : bns_pkg::ST_DIV;
            bns_pkg::ST_DIV: begin
                if (div_x_done && div_y_done) begin
                    state_next = bns_pkg::ST_ROW;
                end
            end
            bns_pkg::ST_ROW:  state_next = bns_pkg::ST_MUL;
            bns_pkg::ST_MUL:  state_next = bns_pkg::ST_ADDR;
            bns_pkg::ST_ADDR: state_next = addr_oor ? bns_pkg::ST_DONE : bns_pkg::ST_B0;
            bns_pkg::ST_B0:   state_next = bns_pkg::ST_B1;
            bns_pkg::ST_B1:   state_next = fmt_pal ? bns_pkg::ST_PAL : bns_pkg::ST_B2;
            bns_pkg::ST_B2:   state_next = bns_pkg::ST_B3;
            bns_pkg::ST_B3:   state_next = bns_pkg::ST_DONE;
            bns_pkg::ST_PAL:  state_next = bns_pkg::ST_DONE;
            bns_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bns_pkg::ST_IDLE;
                end
            end
            default:          state_next = bns_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == bns_pkg::ST_IDLE);
        div_start = (state_reg == bns_pkg::ST_CHK) && !off_screen;
        out_load  = (state_reg == bns_pkg::ST_DONE) && out_free;
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg <= in_x;
            y_reg <= in_y;
        end
        unique case (state_reg)
            bns_pkg::ST_CHK: begin
                res_colour_reg <= '0;
                res_oor_reg    <= off_screen;
            end
            bns_pkg::ST_ROW: begin
                row_reg    <= bottom_up_reg ? (sh_eff - 1'b1 - sy_q) : sy_q;
                stride_reg <= stride_calc;
                sxb_reg    <= sxb_calc;
                sxl_reg    <= fmt_pal ? sxb_calc : (sxb_calc + bns_pkg::SXB_W'(2));
            end
            bns_pkg::ST_MUL: begin
                prod_reg <= bns_pkg::ADDR_W'(row_reg) * bns_pkg::ADDR_W'(stride_reg);
            end
            bns_pkg::ST_ADDR: begin
                addr_reg       <= addr_sum[bns_pkg::STORE_AW-1:0];
                res_colour_reg <= '0;
                res_oor_reg    <= addr_oor;
            end
            bns_pkg::ST_B0: begin
                addr_reg <= addr_reg + 1'b1;
            end
            bns_pkg::ST_B1: begin
                addr_reg            <= addr_reg + 1'b1;
                res_colour_reg[7:0] <= pix_rd_reg;
                pal_ok_reg <= (bns_pkg::ADDR_W'(pix_rd_reg))
                              < bns_pkg::ADDR_W'(bns_pkg::PALETTE_ENTRIES);
            end
            bns_pkg::ST_B2: begin
                addr_reg             <= addr_reg + 1'b1;
                res_colour_reg[15:8] <= pix_rd_reg;
            end
            bns_pkg::ST_B3: begin
                res_colour_reg[23:16] <= pix_rd_reg;
            end
            bns_pkg::ST_PAL: begin
                res_colour_reg <= pal_ok_reg ? pal_rd_reg : '0;
            end
            default: ;
        endcase
    end

    // result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= res_colour_reg;
            m_tuser_reg <= res_oor_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        div_x_done == div_y_done)
        else $error("axis dividers out of step");

    a_sx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bns_pkg::ST_ROW) |-> (sx_q < sw_eff))
        else $error("source column beyond bitmap width");

    a_sy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bns_pkg::ST_ROW) |-> (sy_q < sh_eff))
        else $error("source row beyond bitmap height");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bns_pkg::ST_DONE && !out_free)
        |=> (state_reg == bns_pkg::ST_DONE && $stable(res_colour_reg)))
        else $error("finished result lost while output stalled");

endmodule

`default_nettype wire
